@@ rtl/ltc_pkg.sv @@
// Shared types, constants and a helper function for the linear timecode edge decoder.
// Used by every module in rtl/; depends on nothing else.
package ltc_pkg;

  localparam int unsigned TimeW      = 26;
  localparam int unsigned TimerWrap  = 42949672;
  localparam int unsigned IntervalW  = 27;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);
  localparam int unsigned BitPosW    = 7;
  localparam int unsigned DataW      = 64;
  localparam int unsigned FrameCntW  = 8;
  localparam int unsigned OnesW      = 4;

  localparam logic [CfgW-1:0]      ShortMinReset = 16'd150;
  localparam logic [CfgW-1:0]      LongMinReset  = 16'd380;
  localparam logic [CfgW-1:0]      LongMaxReset  = 16'd600;
  localparam logic [OnesW-1:0]     SyncOnes      = 4'd12;
  localparam logic [BitPosW-1:0]   SyncPos       = 7'd77;
  localparam logic [BitPosW-1:0]   FramePos      = 7'd80;
  localparam logic [BitPosW-1:0]   LastDataPos   = 7'd63;
  localparam logic [FrameCntW-1:0] FrameCntMax   = 8'd255;
  localparam logic [FrameCntW-1:0] FpsFilmMax    = 8'd24;
  localparam logic [FrameCntW-1:0] FpsEbuMax     = 8'd26;
  localparam logic [FrameCntW-1:0] FpsSmpteMin   = 8'd28;
  localparam logic [FrameCntW-1:0] FpsMax        = 8'd30;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHORT_MIN = 2'd0,
    CFG_LONG_MIN  = 2'd1,
    CFG_LONG_MAX  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_TICK      = 2'd0,
    EV_RANGE_ERR = 2'd1,
    EV_SHORT     = 2'd2,
    EV_LONG      = 2'd3
  } ev_kind_e;

  typedef enum logic [2:0] {
    RATE_FILM    = 3'd0,
    RATE_EBU     = 3'd1,
    RATE_DROP    = 3'd2,
    RATE_SMPTE   = 3'd3,
    RATE_UNKNOWN = 3'd4
  } rate_e;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic [BitPosW-1:0] bit_pos;
    logic               sync_seen;
  } back_stat_t;

  function automatic logic [6:0] bcd_to_bin(input logic [2:0] tens, input logic [3:0] units);
    bcd_to_bin = 7'({tens, 3'b000}) + 7'({tens, 1'b0}) + 7'(units);
  endfunction

endpackage

@@ rtl/ltc_front.sv @@
// Front end: holds the configuration registers and the last edge timestamp,
// and classifies each accepted item into a queue event. Depends on ltc_pkg.
module ltc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ltc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ltc_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [ltc_pkg::TimeW-1:0]    edge_time_us_i,
  input  ltc_pkg::fifo_stat_t          fifo_stat_i,
  output logic                         push_o,
  output ltc_pkg::ev_kind_e            push_kind_o
);

  logic [ltc_pkg::CfgW-1:0]      short_min_q;
  logic [ltc_pkg::CfgW-1:0]      long_min_q;
  logic [ltc_pkg::CfgW-1:0]      long_max_q;
  logic [ltc_pkg::TimeW-1:0]     last_time_q;
  logic [ltc_pkg::TimeW-1:0]     last_time_d;
  logic [ltc_pkg::TimeW-1:0]     back_diff;
  logic                          wrapped;
  logic                          wrap_ok;
  logic [ltc_pkg::IntervalW-1:0] interval;
  logic                          in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_min_q <= ltc_pkg::ShortMinReset;
      long_min_q  <= ltc_pkg::LongMinReset;
      long_max_q  <= ltc_pkg::LongMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ltc_pkg::CFG_SHORT_MIN: short_min_q <= cfg_wdata_i;
        ltc_pkg::CFG_LONG_MIN:  long_min_q  <= cfg_wdata_i;
        ltc_pkg::CFG_LONG_MAX:  long_max_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

  assign wrapped   = (last_time_q >= edge_time_us_i);
  assign back_diff = last_time_q - edge_time_us_i;
  assign wrap_ok   = (back_diff != '0) &&
                     (ltc_pkg::IntervalW'(back_diff) < ltc_pkg::IntervalW'(ltc_pkg::TimerWrap));

  always_comb begin
    if (wrapped) begin
      interval = ltc_pkg::IntervalW'(ltc_pkg::TimerWrap) - ltc_pkg::IntervalW'(back_diff);
    end else begin
      interval = ltc_pkg::IntervalW'(edge_time_us_i) - ltc_pkg::IntervalW'(last_time_q);
    end
  end

  assign in_range = (!wrapped || wrap_ok) &&
                    (interval >= ltc_pkg::IntervalW'(short_min_q)) &&
                    (interval <= ltc_pkg::IntervalW'(long_max_q));

  always_comb begin
    last_time_d = last_time_q;
    if (command_i) begin
      push_kind_o = ltc_pkg::EV_TICK;
    end else begin
      last_time_d = edge_time_us_i;
      if (!in_range) begin
        push_kind_o = ltc_pkg::EV_RANGE_ERR;
      end else if (interval > ltc_pkg::IntervalW'(long_min_q)) begin
        push_kind_o = ltc_pkg::EV_LONG;
      end else begin
        push_kind_o = ltc_pkg::EV_SHORT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
    end else if (push_o) begin
      last_time_q <= last_time_d;
    end
  end

endmodule

@@ rtl/ltc_fifo.sv @@
// Short event queue between the front end and the decode back end.
// Depends on ltc_pkg for the depth, pointer widths and event type.
module ltc_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ltc_pkg::ev_kind_e    push_kind_i,
  input  logic                 pop_i,
  output ltc_pkg::ev_kind_e    pop_kind_o,
  output ltc_pkg::fifo_stat_t  stat_o
);

  ltc_pkg::ev_kind_e              entry_q [ltc_pkg::FifoDepth];
  logic [ltc_pkg::FifoPtrW-1:0]   wr_ptr_q;
  logic [ltc_pkg::FifoPtrW-1:0]   rd_ptr_q;
  logic [ltc_pkg::FifoCntW-1:0]   count_q;
  logic [ltc_pkg::FifoCntW-1:0]   count_d;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == ltc_pkg::FifoCntW'(ltc_pkg::FifoDepth));
  assign pop_kind_o   = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_kind_i;
    end
  end

endmodule

@@ rtl/ltc_back.sv @@
// Back end: bit cell assembly, sync detection, frame counting and the result register.
// Depends on ltc_pkg; takes events from ltc_fifo.
module ltc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ltc_pkg::fifo_stat_t          fifo_stat_i,
  input  ltc_pkg::ev_kind_e            ev_kind_i,
  output logic                         pop_o,
  output ltc_pkg::back_stat_t          stat_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [5:0]                   frames_o,
  output logic [6:0]                   seconds_o,
  output logic [6:0]                   minutes_o,
  output logic [5:0]                   hours_o,
  output logic                         drop_frame_o,
  output logic [2:0]                   rate_type_o,
  output logic                         signal_present_o
);

  logic [ltc_pkg::BitPosW-1:0]   bit_pos_q, bit_pos_d;
  logic                          half_q, half_d;
  logic [ltc_pkg::OnesW-1:0]     ones_q, ones_d;
  logic [ltc_pkg::OnesW-1:0]     ones_inc;
  logic                          sync_q, sync_d;
  logic [ltc_pkg::DataW-1:0]     data_q, data_d;
  logic [ltc_pkg::FrameCntW-1:0] fts_q, fts_d;
  logic [ltc_pkg::FrameCntW-1:0] fps_q, fps_d;
  logic                          cell_bit;
  logic                          emit;
  logic                          out_valid_q;
  logic [5:0]                    frames_q;
  logic [6:0]                    seconds_q;
  logic [6:0]                    minutes_q;
  logic [5:0]                    hours_q;
  logic                          drop_q;
  ltc_pkg::rate_e                rate_q;
  logic                          present_q;
  logic [6:0]                    frames_w;
  logic [6:0]                    hours_w;
  ltc_pkg::rate_e                rate_w;

  assign pop_o  = !fifo_stat_i.empty && (!out_valid_q || out_ready_i);
  assign stat_o = '{bit_pos: bit_pos_q, sync_seen: sync_q};

  always_comb begin
    bit_pos_d = bit_pos_q;
    half_d    = half_q;
    ones_d    = ones_q;
    sync_d    = sync_q;
    data_d    = data_q;
    fts_d     = fts_q;
    fps_d     = fps_q;
    cell_bit  = 1'b0;
    ones_inc  = ones_q + 1'b1;
    emit      = 1'b0;
    if (pop_o) begin
      unique case (ev_kind_i)
        ltc_pkg::EV_TICK: begin
          fps_d = fts_q;
          fts_d = '0;
        end
        ltc_pkg::EV_RANGE_ERR: begin
          bit_pos_d = '0;
        end
        ltc_pkg::EV_SHORT, ltc_pkg::EV_LONG: begin
          if (half_q) begin
            half_d = 1'b0;
          end else begin
            if (ev_kind_i == ltc_pkg::EV_LONG) begin
              ones_d = '0;
            end else begin
              cell_bit = 1'b1;
              half_d   = 1'b1;
              if (ones_inc == ltc_pkg::SyncOnes) begin
                ones_d    = '0;
                sync_d    = 1'b1;
                bit_pos_d = ltc_pkg::SyncPos;
              end else begin
                ones_d = ones_inc;
              end
            end
            if (bit_pos_d <= ltc_pkg::LastDataPos) begin
              data_d = {cell_bit, data_q[ltc_pkg::DataW-1:1]};
            end
            bit_pos_d = bit_pos_d + 1'b1;
            if (bit_pos_d == ltc_pkg::FramePos) begin
              bit_pos_d = '0;
              if (sync_d) begin
                sync_d = 1'b0;
                emit   = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (emit && (fts_q != ltc_pkg::FrameCntMax)) begin
      fts_d = fts_q + 1'b1;
    end
  end

  assign frames_w = ltc_pkg::bcd_to_bin({1'b0, data_d[9:8]}, data_d[3:0]);
  assign hours_w  = ltc_pkg::bcd_to_bin({1'b0, data_d[57:56]}, data_d[51:48]);

  always_comb begin
    priority if (data_d[10]) begin
      rate_w = ltc_pkg::RATE_DROP;
    end else if (fps_q <= ltc_pkg::FpsFilmMax) begin
      rate_w = ltc_pkg::RATE_FILM;
    end else if (fps_q <= ltc_pkg::FpsEbuMax) begin
      rate_w = ltc_pkg::RATE_EBU;
    end else if (fps_q >= ltc_pkg::FpsSmpteMin) begin
      rate_w = ltc_pkg::RATE_SMPTE;
    end else begin
      rate_w = ltc_pkg::RATE_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_pos_q   <= '0;
      half_q      <= 1'b0;
      ones_q      <= '0;
      sync_q      <= 1'b0;
      data_q      <= '0;
      fts_q       <= '0;
      fps_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bit_pos_q <= bit_pos_d;
      half_q    <= half_d;
      ones_q    <= ones_d;
      sync_q    <= sync_d;
      data_q    <= data_d;
      fts_q     <= fts_d;
      fps_q     <= fps_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      frames_q  <= frames_w[5:0];
      seconds_q <= ltc_pkg::bcd_to_bin(data_d[26:24], data_d[19:16]);
      minutes_q <= ltc_pkg::bcd_to_bin(data_d[42:40], data_d[35:32]);
      hours_q   <= hours_w[5:0];
      drop_q    <= data_d[10];
      rate_q    <= rate_w;
      present_q <= (fps_q >= ltc_pkg::FpsFilmMax) && (fps_q <= ltc_pkg::FpsMax);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frames_o         = frames_q;
  assign seconds_o        = seconds_q;
  assign minutes_o        = minutes_q;
  assign hours_o          = hours_q;
  assign drop_frame_o     = drop_q;
  assign rate_type_o      = rate_q;
  assign signal_present_o = present_q;

endmodule

@@ rtl/ltc_timecode_edge_decoder.sv @@
// Top level of the linear timecode edge decoder.
// Instantiates ltc_front, ltc_fifo and ltc_back; depends on ltc_pkg.
//
// Usage: each input transaction carries a command (edge or one-second tick) and
// an edge timestamp in microseconds. The front end measures the interval since
// the previous edge against the three configuration registers and writes one
// event per transaction into a four-entry queue. The back end takes one event
// per cycle while its output register is free or being taken, assembles bit
// cells, detects sync and, when a frame completes, loads one output transaction
// with the decoded time and rate guess. Throughput is one input transaction per
// cycle while the queue is not full; the queue plus the output register set the
// figure. A frame's last edge is queued, then the result is registered. When the
// receiver stalls, the back end holds and the queue fills; in_ready_o drops
// once four events wait. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must do so only while the block is idle,
// which the block does not enforce. Reset restores the default thresholds
// and clears all decode state, the queue pointers and the output valid flag.
module ltc_timecode_edge_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ltc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ltc_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [ltc_pkg::TimeW-1:0]    edge_time_us_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [5:0]                   frames_o,
  output logic [6:0]                   seconds_o,
  output logic [6:0]                   minutes_o,
  output logic [5:0]                   hours_o,
  output logic                         drop_frame_o,
  output logic [2:0]                   rate_type_o,
  output logic                         signal_present_o
);

  ltc_pkg::fifo_stat_t fifo_stat;
  ltc_pkg::back_stat_t back_stat;
  ltc_pkg::ev_kind_e   push_kind;
  ltc_pkg::ev_kind_e   pop_kind;
  logic                push;
  logic                pop;

  ltc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .edge_time_us_i (edge_time_us_i),
    .fifo_stat_i    (fifo_stat),
    .push_o         (push),
    .push_kind_o    (push_kind)
  );

  ltc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_kind_i (push_kind),
    .pop_i       (pop),
    .pop_kind_o  (pop_kind),
    .stat_o      (fifo_stat)
  );

  ltc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fifo_stat_i      (fifo_stat),
    .ev_kind_i        (pop_kind),
    .pop_o            (pop),
    .stat_o           (back_stat),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frames_o         (frames_o),
    .seconds_o        (seconds_o),
    .minutes_o        (minutes_o),
    .hours_o          (hours_o),
    .drop_frame_o     (drop_frame_o),
    .rate_type_o      (rate_type_o),
    .signal_present_o (signal_present_o)
  );

  a_rate_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((rate_type_o == ltc_pkg::RATE_DROP) == drop_frame_o))
    else $error("Rate type disagrees with the drop-frame flag.");

  a_bit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.bit_pos < ltc_pkg::FramePos)
    else $error("Bit position reached the frame length without wrapping.");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!fifo_stat.empty))
    else $error("Result appeared without a queued event.");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frames_o <= 6'd45) && (hours_o <= 6'd45) &&
                    (seconds_o <= 7'd85) && (minutes_o <= 7'd85))
    else $error("Decoded time field out of range.");

endmodule

@@ test/ltc_timecode_checker.sv @@
// Stimulus command codes and the checker for the linear timecode edge decoder.
// The checker watches the ports of ltc_timecode_edge_decoder, predicts each decoded frame
// and compares it field by field; it depends on ltc_pkg for port widths and types.
package ltc_tb_pkg;

  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_TICK = 1'b1
  } ltc_cmd_e;

endpackage

module ltc_timecode_checker
  import ltc_pkg::*;
  import ltc_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               command_i,
  input  logic [TimeW-1:0]   edge_time_us_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [5:0]         frames_i,
  input  logic [6:0]         seconds_i,
  input  logic [6:0]         minutes_i,
  input  logic [5:0]         hours_i,
  input  logic               drop_frame_i,
  input  logic [2:0]         rate_type_i,
  input  logic               signal_present_i,
  output int                 mismatches_o,
  output int                 frames_due_o,
  output int                 frames_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WrapUs      = 42949672;
  localparam logic [3:0]  SyncRun     = 4'd12;
  localparam logic [6:0]  SyncCellPos = 7'd77;
  localparam logic [6:0]  FrameCells  = 7'd80;
  localparam logic [6:0]  DataCells   = 7'd64;
  localparam logic [7:0]  CountCeil   = 8'd255;
  localparam int unsigned FilmTop     = 24;
  localparam int unsigned EbuTop      = 26;
  localparam int unsigned SmpteLow    = 28;
  localparam int unsigned PresentTop  = 30;
  localparam logic [15:0] ShortMinDflt = 16'd150;
  localparam logic [15:0] LongMinDflt  = 16'd380;
  localparam logic [15:0] LongMaxDflt  = 16'd600;

  typedef struct packed {
    logic [5:0] frames;
    logic [6:0] seconds;
    logic [6:0] minutes;
    logic [5:0] hours;
    logic       drop;
    rate_e      rate;
    logic       present;
  } timecode_t;

  logic [15:0] short_min_q, long_min_q, long_max_q;
  logic [25:0] prev_stamp;
  logic [6:0]  cell_pos;
  logic        half_cell;
  logic [3:0]  ones_cnt;
  logic        sync_armed;
  logic [63:0] tc_bits;
  logic [7:0]  frame_cnt;
  logic [7:0]  fps_latched;
  timecode_t   timecode_q[$];

  int mismatch_cnt = 0;
  int due_cnt      = 0;
  int checked_cnt  = 0;

  assign mismatches_o     = mismatch_cnt;
  assign frames_due_o     = due_cnt;
  assign frames_checked_o = checked_cnt;

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t ns: timecode mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic decode_event(input logic cmd, input logic [25:0] stamp);
    int unsigned gap;
    int unsigned back;
    logic        in_range;
    logic        bit_val;
    timecode_t   tc;
    if (cmd == CMD_TICK) begin
      fps_latched = frame_cnt;
      frame_cnt   = '0;
      return;
    end
    in_range = 1'b1;
    gap      = 0;
    if (prev_stamp >= stamp) begin
      back     = prev_stamp - stamp;
      in_range = (back != 0) && (back < WrapUs);
      if (in_range) gap = WrapUs - back;
    end else begin
      gap = stamp - prev_stamp;
    end
    prev_stamp = stamp;
    if (in_range && (gap < short_min_q || gap > long_max_q)) in_range = 1'b0;
    if (!in_range) begin
      cell_pos = '0;
      return;
    end
    if (half_cell) begin
      half_cell = 1'b0;
      return;
    end
    bit_val = (gap <= long_min_q);
    if (!bit_val) begin
      ones_cnt = '0;
    end else begin
      half_cell = 1'b1;
      ones_cnt  = ones_cnt + 4'd1;
      if (ones_cnt == SyncRun) begin
        ones_cnt   = '0;
        sync_armed = 1'b1;
        cell_pos   = SyncCellPos;
      end
    end
    if (cell_pos < DataCells) tc_bits = {bit_val, tc_bits[63:1]};
    cell_pos = cell_pos + 7'd1;
    if (cell_pos != FrameCells) return;
    cell_pos = '0;
    if (!sync_armed) return;
    sync_armed = 1'b0;
    if (frame_cnt != CountCeil) frame_cnt = frame_cnt + 8'd1;

    tc.frames  = 6'(10 * tc_bits[9:8] + tc_bits[3:0]);
    tc.seconds = 7'(10 * tc_bits[26:24] + tc_bits[19:16]);
    tc.minutes = 7'(10 * tc_bits[42:40] + tc_bits[35:32]);
    tc.hours   = 6'(10 * tc_bits[57:56] + tc_bits[51:48]);
    tc.drop    = tc_bits[10];
    if (tc.drop) tc.rate = RATE_DROP;
    else if (fps_latched <= FilmTop) tc.rate = RATE_FILM;
    else if (fps_latched <= EbuTop) tc.rate = RATE_EBU;
    else if (fps_latched >= SmpteLow) tc.rate = RATE_SMPTE;
    else tc.rate = RATE_UNKNOWN;
    tc.present = (fps_latched >= FilmTop) && (fps_latched <= PresentTop);
    timecode_q.push_back(tc);
  endtask

  task automatic check_timecode();
    timecode_t want;
    if (timecode_q.size() == 0) begin
      report_mismatch($sformatf("result with no decoded frame due, frames %0d", frames_i));
      return;
    end
    want = timecode_q.pop_front();
    checked_cnt++;
    compare_field("frames", frames_i, want.frames);
    compare_field("seconds", seconds_i, want.seconds);
    compare_field("minutes", minutes_i, want.minutes);
    compare_field("hours", hours_i, want.hours);
    compare_field("drop_frame", drop_frame_i, want.drop);
    compare_field("rate_type", rate_type_i, want.rate);
    compare_field("signal_present", signal_present_i, want.present);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_min_q = ShortMinDflt;
      long_min_q  = LongMinDflt;
      long_max_q  = LongMaxDflt;
      prev_stamp  = '0;
      cell_pos    = '0;
      half_cell   = 1'b0;
      ones_cnt    = '0;
      sync_armed  = 1'b0;
      tc_bits     = '0;
      frame_cnt   = '0;
      fps_latched = '0;
      timecode_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_timecode();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SHORT_MIN: short_min_q = cfg_wdata_i;
          CFG_LONG_MIN:  long_min_q  = cfg_wdata_i;
          CFG_LONG_MAX:  long_max_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) decode_event(command_i, edge_time_us_i);
    end
    due_cnt = timecode_q.size();
  end

endmodule

@@ test/testbench.sv @@
// Top of the testbench for ltc_timecode_edge_decoder: clock, reset, edge and tick stimulus,
// threshold register writes and the verdict. Depends on ltc_pkg, ltc_tb_pkg and the
// ltc_timecode_checker module, which predicts and compares every decoded frame.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ltc_pkg::*;
  import ltc_tb_pkg::*;

  localparam int unsigned StampWrap    = 42949672;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned DrainLimit   = 10000;
  localparam logic [15:0] SyncTailBits   = 16'b1011_1111_1111_1100;
  localparam logic [14:0] ShortFrameBits = 15'b001_1111_1111_1110;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i      = CFG_SHORT_MIN;
  logic [CfgW-1:0]    cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               command_i      = CMD_EDGE;
  logic [TimeW-1:0]   edge_time_us_i = '0;
  logic               out_ready_i    = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [5:0]         frames_o;
  logic [6:0]         seconds_o;
  logic [6:0]         minutes_o;
  logic [5:0]         hours_o;
  logic               drop_frame_o;
  logic [2:0]         rate_type_o;
  logic               signal_present_o;

  int mismatches;
  int frames_due;
  int frames_checked;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned stamp_now      = 0;
  logic [15:0] short_set      = 16'd150;
  logic [15:0] long_min_set   = 16'd380;
  logic [15:0] long_max_set   = 16'd600;
  int          items_sent     = 0;
  int          ticks_sent     = 0;
  int          settings_used  = 1;

  ltc_timecode_edge_decoder i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .edge_time_us_i,
    .out_valid_o,
    .out_ready_i,
    .frames_o,
    .seconds_o,
    .minutes_o,
    .hours_o,
    .drop_frame_o,
    .rate_type_o,
    .signal_present_o
  );

  ltc_timecode_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_i       (in_ready_o),
    .command_i,
    .edge_time_us_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .frames_i         (frames_o),
    .seconds_i        (seconds_o),
    .minutes_i        (minutes_o),
    .hours_i          (hours_o),
    .drop_frame_i     (drop_frame_o),
    .rate_type_i      (rate_type_o),
    .signal_present_i (signal_present_o),
    .mismatches_o     (mismatches),
    .frames_due_o     (frames_due),
    .frames_checked_o (frames_checked)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 69;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 69;
      end
      default: begin
        send_idle_pct  = 7;
        recv_stall_pct = 7;
      end
    endcase
  endtask

  task automatic send_item(input ltc_cmd_e cmd, input logic [TimeW-1:0] stamp);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    edge_time_us_i <= stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (cmd == CMD_TICK) ticks_sent++;
  endtask

  function automatic int unsigned pick_gap(input logic one_cell);
    int unsigned lo;
    int unsigned hi;
    if (one_cell) begin
      lo = (short_set > 0) ? short_set : 1;
      hi = (long_min_set < long_max_set) ? long_min_set : long_max_set;
    end else begin
      lo = long_min_set + 1;
      if (short_set > lo) lo = short_set;
      hi = long_max_set;
    end
    if (lo > hi) return $urandom_range(2000, 1);
    case ($urandom_range(3, 0))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic send_edge(input int unsigned gap);
    stamp_now = (stamp_now + gap) % StampWrap;
    send_item(CMD_EDGE, TimeW'(stamp_now));
  endtask

  task automatic send_bits(input logic [63:0] pattern, input int count);
    for (int i = 0; i < count; i++) begin
      if (pattern[i]) begin
        send_edge(pick_gap(1'b1));
        send_edge(pick_gap(1'b1));
      end else begin
        send_edge(pick_gap(1'b0));
      end
    end
  endtask

  task automatic send_frame(input logic [63:0] data);
    send_bits(data, 64);
    send_bits(64'(SyncTailBits), 16);
  endtask

  task automatic send_noise(input int count);
    repeat (count) begin
      case ($urandom_range(4, 0))
        0: send_item(CMD_EDGE, TimeW'(stamp_now));
        1: begin
          stamp_now = $urandom_range(32'h03FF_FFFF, 0);
          send_item(CMD_EDGE, TimeW'(stamp_now));
        end
        2: send_edge($urandom_range(short_set, 0));
        3: send_edge(long_max_set + $urandom_range(50, 1));
        default: send_edge(pick_gap($urandom_range(1, 0)));
      endcase
    end
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (frames_due != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [15:0] short_min, input logic [15:0] long_min,
                                input logic [15:0] long_max);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SHORT_MIN;
    cfg_wdata_i <= short_min;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_LONG_MIN;
    cfg_wdata_i <= long_min;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_LONG_MAX;
    cfg_wdata_i <= long_max;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    short_set    = short_min;
    long_min_set = long_min;
    long_max_set = long_max;
    settings_used++;
  endtask

  initial begin
    int          fps_goal;
    logic [15:0] s_min;
    logic [15:0] l_min;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Default thresholds: limits of each interval class, wrap-around and stale stamps.
    send_item(CMD_EDGE, 26'd0);
    send_item(CMD_EDGE, 26'd150);
    send_item(CMD_EDGE, 26'd750);
    send_item(CMD_EDGE, 26'd1131);
    send_item(CMD_EDGE, 26'd1511);
    send_item(CMD_EDGE, 26'd1660);
    send_item(CMD_EDGE, 26'd2261);
    send_item(CMD_EDGE, 26'h3FF_FFFF);
    send_item(CMD_EDGE, 26'd100);
    send_item(CMD_EDGE, 26'd42949671);
    send_item(CMD_EDGE, 26'd399);
    send_item(CMD_TICK, 26'h3FF_FFFF);
    send_item(CMD_TICK, 26'd0);
    stamp_now = 399;

    write_settings(16'd0, 16'd0, 16'd0);
    send_noise(12);
    repeat (8) send_edge($urandom_range(3, 1));

    write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_edge(65534);
    send_edge(65536);
    repeat (28) send_edge(65535);

    write_settings(16'd0, 16'hFFFE, 16'hFFFF);
    send_edge(1);
    send_bits({$urandom, $urandom}, 8);

    write_settings(16'd500, 16'd100, 16'd800);
    send_noise(10);
    send_bits({$urandom, $urandom}, 8);

    // One busy second under random thresholds, stepping through every idling phase.
    s_min = 16'($urandom_range(400, 20));
    l_min = 16'(s_min + $urandom_range(400, 1));
    write_settings(s_min, l_min, 16'(l_min + $urandom_range(600, 1)));
    fps_goal = $urandom_range(27, 21);
    send_frame({$urandom, $urandom});
    for (int n = 1; n < fps_goal; n++) begin
      set_idling(idle_mode_e'(n % 4));
      if ($urandom_range(9, 0) == 0) send_noise($urandom_range(4, 1));
      send_bits(64'(ShortFrameBits), 15);
    end
    send_item(CMD_TICK, TimeW'($urandom));

    // A frame that reports the busy second's rate, then one after an empty second.
    write_settings(16'd150, 16'd380, 16'd600);
    set_idling(IDLE_NONE);
    send_bits(64'(ShortFrameBits), 15);
    send_item(CMD_TICK, TimeW'($urandom));
    send_item(CMD_TICK, TimeW'($urandom));
    set_idling(IDLE_BOTH);
    send_bits(64'(ShortFrameBits), 15);

    settle();
    repeat (50) @(negedge clk_i);
    $display("Sent %0d transactions (%0d ticks) under %0d threshold settings;",
             items_sent, ticks_sent, settings_used);
    $display("checked %0d decoded timecode results.", frames_checked);
    if (mismatches == 0 && frames_due == 0) begin
      $display("testbench OK");
    end else begin
      if (frames_due != 0) $display("%0d decoded frames never came out", frames_due);
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Run timed out.");
    $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ltc_pkg.sv
rtl/ltc_front.sv
rtl/ltc_fifo.sv
rtl/ltc_back.sv
rtl/ltc_timecode_edge_decoder.sv
test/ltc_timecode_checker.sv
test/testbench.sv
